// File: hdl/pfl_pkg.sv
// ----------------------------------------------------------------------------
// pfl_pkg
// Shared types and codes of the per-cpu page free list: word layouts,
// operation and status codes, register indexes, controller/datapath bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package pfl_pkg;

    // operation codes of an input word
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_INIT  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // status codes of a result word
    localparam logic [2:0] ST_ALLOC = 3'd0;
    localparam logic [2:0] ST_OOM   = 3'd1;
    localparam logic [2:0] ST_FREED = 3'd2;
    localparam logic [2:0] ST_BAD   = 3'd3;
    localparam logic [2:0] ST_INIT  = 3'd4;

    // configuration register indexes and reset values
    localparam int          CFG_IDX_W      = 4;
    localparam logic [3:0]  REG_MEM_START  = 4'd0;
    localparam logic [3:0]  REG_MEM_STOP   = 4'd1;
    localparam logic [31:0] MEM_START_INIT = 32'h8000_0000;
    localparam logic [31:0] MEM_STOP_INIT  = 32'h8800_0000;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [2:0]  cpu_id;
        logic [31:0] page_addr;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] result_addr;
        logic [2:0]  source_cpu;
        logic        stolen;
    } out_word_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic       load_item;
        logic       mod_start;
        logic       mod_base;
        logic       base_latch;
        logic       pick;
        logic       mem_rd;
        logic       pop;
        logic       free_push;
        logic       init_setup;
        logic       init_push;
        logic       set_status;
        logic [2:0] status_code;
        logic       out_load;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic       base_ok;
        logic       mod_done;
        logic [1:0] op;
        logic       any_ok;
        logic       bad_free;
        logic       init_more;
        logic       out_free;
    } stat_t;

endpackage

`default_nettype wire

// File: hdl/pfl_mod.sv
// ----------------------------------------------------------------------------
// pfl_mod
// Page number modulo the page count. A mask for a power-of-two count,
// otherwise a registered reciprocal multiply and back multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module pfl_mod
#(
    parameter int NUM_PAGES = 32768,
    parameter int OP_W      = 21
)
(
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire logic                                          start,
    input  wire logic [OP_W-1:0]                               operand,
    output logic                                               done,
    output logic [((NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1)-1:0] result
);

    localparam int IDX_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam bit POW2  = ((NUM_PAGES & (NUM_PAGES - 1)) == 0);

    generate
        if (POW2) begin : g_mask
            logic             done_reg;
            logic [IDX_W-1:0] res_reg;

            // low bits are the remainder
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    res_reg <= operand[IDX_W-1:0];
                end
            end

            assign done   = done_reg;
            assign result = res_reg;
        end
        else begin : g_recip
            // exact quotient: ceil(2^(OP_W+IDX_W) / NUM_PAGES), shift by OP_W+IDX_W
            localparam int              QW      = OP_W + 1 - IDX_W;
            localparam int              SH      = OP_W + IDX_W;
            localparam longint unsigned MAGIC   = ((64'd1 << SH) + 64'(NUM_PAGES) - 64'd1)
                                                  / 64'(NUM_PAGES);
            localparam logic [OP_W:0]   MAGIC_V = (OP_W + 1)'(MAGIC);

            logic             p1_reg;
            logic             p2_reg;
            logic             done_reg;
            logic [OP_W-1:0]  opd_reg;
            logic [QW-1:0]    q_reg;
            logic [IDX_W-1:0] rem_reg;
            logic [2*OP_W:0]  prod;
            logic [OP_W:0]    qn;
            logic [OP_W:0]    diff;

            // quotient by reciprocal, then operand minus quotient times count
            assign prod = {{(OP_W + 1){1'b0}}, opd_reg} * {{OP_W{1'b0}}, MAGIC_V};
            assign qn   = {{IDX_W{1'b0}}, q_reg} * {{QW{1'b0}}, IDX_W'(NUM_PAGES)};
            assign diff = {1'b0, opd_reg} - qn;

            // stage control
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    p1_reg   <= 1'b0;
                    p2_reg   <= 1'b0;
                    done_reg <= 1'b0;
                end
                else
                begin
                    p1_reg   <= start;
                    p2_reg   <= p1_reg;
                    done_reg <= p2_reg;
                end
            end

            // operand, quotient and remainder
            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    opd_reg <= operand;
                end
                if (p1_reg)
                begin
                    q_reg <= prod[2*OP_W:SH];
                end
                if (p2_reg)
                begin
                    rem_reg <= diff[IDX_W-1:0];
                end
            end

            assign done   = done_reg;
            assign result = rem_reg;
        end
    endgenerate

    // a result is reported once per start
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("modulo unit done held for two cycles");

endmodule

`default_nettype wire

// File: hdl/pfl_datapath.sv
// ----------------------------------------------------------------------------
// pfl_datapath
// Configuration registers, list heads, link memory, address arithmetic,
// init walker and the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module pfl_datapath
    import pfl_pkg::*;
#(
    parameter int NUM_CPUS   = 8,
    parameter int NUM_PAGES  = 32768,
    parameter int PAGE_SHIFT = 12
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cmd_t                 cmd,
    output stat_t                     stat,
    input  wire in_word_t             in_word,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output out_word_t                 out_word
);

    localparam int IDX_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int CPU_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int OP_W  = 33 - PAGE_SHIFT;
    localparam logic [32:0] PG_MASK = 33'((64'd1 << PAGE_SHIFT) - 64'd1);

    // configuration
    logic [31:0]      mem_start_reg;
    logic [31:0]      mem_stop_reg;
    logic             base_ok_reg;
    logic [IDX_W-1:0] base_mod_reg;

    // current item
    logic [1:0]       op_reg;
    logic [CPU_W-1:0] cpu_reg;
    logic [31:0]      pa_reg;
    logic [CPU_W-1:0] from_reg;
    logic [2:0]       res_status_reg;

    // list heads
    logic             head_ok_reg  [NUM_CPUS];
    logic [IDX_W-1:0] head_idx_reg [NUM_CPUS];

    // link memory, bit IDX_W marks a valid successor
    logic [IDX_W:0]   link_mem [NUM_PAGES];
    logic [IDX_W:0]   rd_data_reg;
    logic [IDX_W-1:0] off_reg;

    // init walker
    logic [OP_W-1:0]  pg_reg;
    logic [IDX_W-1:0] iidx_reg;
    logic [IDX_W:0]   n_reg;

    // output register
    logic             out_valid_reg;
    out_word_t        out_reg;

    logic [4:0]       cpu_red;
    logic [CPU_W-1:0] cpu_in;
    logic [CPU_W-1:0] hsel;
    logic [CPU_W-1:0] first_cpu;
    logic             any_ok;
    logic [32:0]      start_round;
    logic [OP_W-1:0]  base_pg;
    logic [OP_W-1:0]  mod_operand;
    logic             mod_done;
    logic [IDX_W-1:0] mod_res;
    logic [IDX_W:0]   push_link;
    logic             link_we;
    logic [IDX_W-1:0] link_wa;
    logic [IDX_W-1:0] pop_idx;
    logic [IDX_W:0]   off_wrap;
    logic [IDX_W-1:0] off_next;
    logic [OP_W:0]    page_sum;
    logic [OP_W+PAGE_SHIFT:0] addr_wide;
    logic [4:0]       from_ext;
    logic             is_alloc;
    logic             bad_free;
    logic             init_more;
    logic             out_free;

    // requester cpu folded into the cpu count
    always_comb
    begin
        cpu_red = {2'b00, in_word.cpu_id};
        for (int k = 0; k < 7; k++)
        begin
            if (cpu_red >= 5'(NUM_CPUS))
            begin
                cpu_red = cpu_red - 5'(NUM_CPUS);
            end
        end
        cpu_in = cpu_red[CPU_W-1:0];
    end

    // lowest whole page at or above mem_start
    assign start_round = {1'b0, mem_start_reg} + PG_MASK;
    assign base_pg     = start_round[32:PAGE_SHIFT];

    // page number modulo the page count
    assign mod_operand = cmd.mod_base ? base_pg : {1'b0, pa_reg[31:PAGE_SHIFT]};

    pfl_mod #(
        .NUM_PAGES (NUM_PAGES),
        .OP_W      (OP_W)
    ) u_mod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mod_start),
        .operand (mod_operand),
        .done    (mod_done),
        .result  (mod_res)
    );

    // head accessed by this item: the source for alloc, the requester otherwise
    assign hsel = (op_reg == OP_ALLOC) ? from_reg : cpu_reg;

    // first non-empty list from cpu 0 upward
    always_comb
    begin
        first_cpu = '0;
        any_ok    = 1'b0;
        for (int i = 0; i < NUM_CPUS; i++)
        begin
            if (!any_ok && head_ok_reg[i])
            begin
                first_cpu = CPU_W'(i);
                any_ok    = 1'b1;
            end
        end
    end

    // link to the old head for a push
    assign push_link = head_ok_reg[hsel] ? {1'b1, head_idx_reg[hsel]} : '0;
    assign link_we   = cmd.free_push || cmd.init_push;
    assign link_wa   = cmd.free_push ? mod_res : iidx_reg;

    // popped index relative to the base window
    assign pop_idx  = head_idx_reg[hsel];
    assign off_wrap = {1'b0, pop_idx} + (IDX_W + 1)'(NUM_PAGES) - {1'b0, base_mod_reg};
    assign off_next = (pop_idx >= base_mod_reg) ? (pop_idx - base_mod_reg)
                                                : off_wrap[IDX_W-1:0];

    // allocated address from base page and offset
    assign page_sum  = {1'b0, base_pg} + (OP_W + 1)'(off_reg);
    assign addr_wide = {page_sum, {PAGE_SHIFT{1'b0}}};
    assign from_ext  = 5'(from_reg);
    assign is_alloc  = (res_status_reg == ST_ALLOC);

    // free address check and init bound
    assign bad_free  = (pa_reg[PAGE_SHIFT-1:0] != '0) || (pa_reg < mem_start_reg)
                       || (pa_reg >= mem_stop_reg);
    assign init_more = (n_reg < (IDX_W + 1)'(NUM_PAGES))
                       && (pg_reg < OP_W'(mem_stop_reg[31:PAGE_SHIFT]));
    assign out_free  = !out_valid_reg || !out_stall;

    // control state of the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_start_reg <= MEM_START_INIT;
            mem_stop_reg  <= MEM_STOP_INIT;
            base_ok_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CPUS; i++)
            begin
                head_ok_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cfg_we && cfg_index == REG_MEM_START)
            begin
                mem_start_reg <= cfg_data;
                base_ok_reg   <= 1'b0;
            end
            else if (cmd.base_latch)
            begin
                base_ok_reg <= 1'b1;
            end
            if (cfg_we && cfg_index == REG_MEM_STOP)
            begin
                mem_stop_reg <= cfg_data;
            end

            if (cmd.pop)
            begin
                head_ok_reg[hsel] <= rd_data_reg[IDX_W];
            end
            else if (cmd.free_push || cmd.init_push)
            begin
                head_ok_reg[hsel] <= 1'b1;
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item, head index and walker payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg  <= in_word.opcode;
            cpu_reg <= cpu_in;
            pa_reg  <= in_word.page_addr;
        end
        if (cmd.base_latch)
        begin
            base_mod_reg <= mod_res;
        end
        if (cmd.pick)
        begin
            from_reg <= head_ok_reg[cpu_reg] ? cpu_reg : first_cpu;
        end
        if (cmd.set_status)
        begin
            res_status_reg <= cmd.status_code;
        end

        if (cmd.pop)
        begin
            head_idx_reg[hsel] <= rd_data_reg[IDX_W-1:0];
            off_reg            <= off_next;
        end
        else if (cmd.free_push)
        begin
            head_idx_reg[hsel] <= mod_res;
        end
        else if (cmd.init_push)
        begin
            head_idx_reg[hsel] <= iidx_reg;
        end

        if (cmd.init_setup)
        begin
            pg_reg   <= base_pg;
            iidx_reg <= base_mod_reg;
            n_reg    <= '0;
        end
        else if (cmd.init_push)
        begin
            pg_reg <= pg_reg + OP_W'(1);
            n_reg  <= n_reg + (IDX_W + 1)'(1);
            if (iidx_reg == IDX_W'(NUM_PAGES - 1))
            begin
                iidx_reg <= '0;
            end
            else
            begin
                iidx_reg <= iidx_reg + IDX_W'(1);
            end
        end

        if (cmd.out_load)
        begin
            out_reg.status      <= res_status_reg;
            out_reg.result_addr <= is_alloc ? addr_wide[31:0] : '0;
            out_reg.source_cpu  <= is_alloc ? from_ext[2:0] : '0;
            out_reg.stolen      <= is_alloc && (from_reg != cpu_reg);
        end
    end

    // link memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_wa] <= push_link;
        end
        if (cmd.mem_rd)
        begin
            rd_data_reg <= link_mem[pop_idx];
        end
    end

    assign stat.base_ok   = base_ok_reg;
    assign stat.mod_done  = mod_done;
    assign stat.op        = op_reg;
    assign stat.any_ok    = any_ok;
    assign stat.bad_free  = bad_free;
    assign stat.init_more = init_more;
    assign stat.out_free  = out_free;

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    // a waiting result word is never overwritten
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !out_stall))
        else $error("result word loaded over a stalled word");

    // a pop only takes from a non-empty list
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> head_ok_reg[hsel])
        else $error("pop from an empty list");

endmodule

`default_nettype wire

// File: hdl/pfl_ctrl.sv
// ----------------------------------------------------------------------------
// pfl_ctrl
// Sequencer of the page free list: takes one word at a time, steps the datapath
// through alloc, free and init and hands the result over; OP_NONE gives none.
// ----------------------------------------------------------------------------
`default_nettype none

module pfl_ctrl
    import pfl_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [1:0] opcode,
    input  wire stat_t      stat,
    output cmd_t            cmd,
    output logic            idle
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_BMOD  = 11'b000_0000_0010,
        S_PICK  = 11'b000_0000_0100,
        S_READ  = 11'b000_0000_1000,
        S_POP   = 11'b000_0001_0000,
        S_CHECK = 11'b000_0010_0000,
        S_FMOD  = 11'b000_0100_0000,
        S_PUSH  = 11'b000_1000_0000,
        S_ISET  = 11'b001_0000_0000,
        S_ILOOP = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign idle   = (state_reg == S_IDLE);
    assign accept = in_valid && idle;

    // next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_item = 1'b1;
                    priority if (opcode == OP_FREE)
                    begin
                        state_next = S_CHECK;
                    end
                    else if (opcode == OP_NONE)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (!stat.base_ok)
                    begin
                        cmd.mod_start = 1'b1;
                        cmd.mod_base  = 1'b1;
                        state_next    = S_BMOD;
                    end
                    else if (opcode == OP_ALLOC)
                    begin
                        state_next = S_PICK;
                    end
                    else
                    begin
                        state_next = S_ISET;
                    end
                end
            end
            S_BMOD:
            begin
                if (stat.mod_done)
                begin
                    cmd.base_latch = 1'b1;
                    state_next     = (stat.op == OP_ALLOC) ? S_PICK : S_ISET;
                end
            end
            S_PICK:
            begin
                cmd.pick = 1'b1;
                if (stat.any_ok)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_OOM;
                    state_next      = S_DONE;
                end
            end
            S_READ:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_POP;
            end
            S_POP:
            begin
                cmd.pop         = 1'b1;
                cmd.set_status  = 1'b1;
                cmd.status_code = ST_ALLOC;
                state_next      = S_DONE;
            end
            S_CHECK:
            begin
                if (stat.bad_free)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_BAD;
                    state_next      = S_DONE;
                end
                else
                begin
                    cmd.mod_start = 1'b1;
                    state_next    = S_FMOD;
                end
            end
            S_FMOD:
            begin
                if (stat.mod_done)
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                cmd.free_push   = 1'b1;
                cmd.set_status  = 1'b1;
                cmd.status_code = ST_FREED;
                state_next      = S_DONE;
            end
            S_ISET:
            begin
                cmd.init_setup = 1'b1;
                state_next     = S_ILOOP;
            end
            S_ILOOP:
            begin
                if (stat.init_more)
                begin
                    cmd.init_push = 1'b1;
                end
                else
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_INIT;
                    state_next      = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // an unknown opcode is absorbed without a result
    a_none_absorbed: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && opcode == OP_NONE) |=> (state_reg == S_IDLE))
        else $error("unknown opcode left the idle state");

    // a pop uses link data read in the cycle before
    a_pop_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> $past(cmd.mem_rd))
        else $error("pop without a preceding link read");

endmodule

`default_nettype wire

// File: hdl/per_cpu_page_free_list.sv
// ----------------------------------------------------------------------------
// per_cpu_page_free_list
// Physical page allocator with one LIFO free list per cpu and stealing from
// the lowest non-empty list when the requester's list is empty.
//
//   channel   direction  handshake           word
//   in        into       in_valid/in_stall   in_word   (opcode, cpu_id, page_addr)
//   out       out of     out_valid/out_stall out_word  (status, result_addr,
//                                                       source_cpu, stolen)
//   cfg       into       cfg_valid/cfg_ready cfg_index, cfg_data
//
// One word at a time: an alloc steps through pick, link read, pop and result;
// a free checks the address, takes the page remainder, pushes and gives the
// result; out of memory and a bad free go straight to the result; init pushes
// the pages of the window: the single link memory write port moves one page
// a cycle. The first alloc or init after reset or a mem_start write first takes
// the base page remainder. When NUM_PAGES is not a power of two the remainder
// unit uses a reciprocal multiply in place of a mask. A new word is taken while
// the previous result still waits on out_stall. Reset empties every list; the link memory needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module per_cpu_page_free_list
    import pfl_pkg::*;
#(
    parameter int NUM_CPUS   = 8,
    parameter int NUM_PAGES  = 32768,
    parameter int PAGE_SHIFT = 12
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire in_word_t             in_word,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output out_word_t                 out_word,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data
);

    cmd_t  cmd;
    stat_t stat;
    logic  idle;

    // configuration is always taken
    assign cfg_ready = 1'b1;
    assign in_stall  = !idle;

    pfl_datapath #(
        .NUM_CPUS   (NUM_CPUS),
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_word   (in_word),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    pfl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (in_word.opcode),
        .stat     (stat),
        .cmd      (cmd),
        .idle     (idle)
    );

endmodule

`default_nettype wire

// File: tb/per_cpu_page_free_list_tb.sv
// ----------------------------------------------------------------------------
// per_cpu_page_free_list_tb
// Self-checking bench for the per-cpu page free list. A directed table covers
// bad frees, out of memory, stealing, lifo order, double free, the unused
// opcode and a full init. Random phases follow under many memory windows,
// the edges of the address space among them. Every result word is checked
// against the table's fixed word where one is given, else an allocator model.
// ----------------------------------------------------------------------------
module per_cpu_page_free_list_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfl_pkg::*;

    localparam int          NCPU        = 8;
    localparam int          NPG         = 32768;
    localparam int          PSH         = 12;
    localparam logic [63:0] PG_BYTES    = 64'd1 << PSH;
    localparam int          IDLE_PCT    = 14;
    localparam int          HOLD_CYCLES = 300;
    localparam int          SETTLE      = 12;
    localparam int          RAND_ITEMS  = 1750;
    localparam int          PHASE_ITEMS = 150;
    localparam int          SMALL_INIT  = 64;
    localparam int          CALM_PHASE  = 3;
    localparam int          HOLD_PHASE  = 4;
    localparam int          PAUSE_PHASE = 5;
    localparam int          DIR_ROWS    = 25;
    localparam out_word_t   NO_FIX      = '0;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    in_word_t             in_word   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_word_t            out_word;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;

    // allocator model: bounds, list heads and link memory
    logic [31:0] cur_start = MEM_START_INIT;
    logic [31:0] cur_stop  = MEM_STOP_INIT;
    logic [15:0] head_page [NCPU];
    bit          head_used [NCPU];
    bit   [16:0] link_ram  [NPG];

    out_word_t   expected_words [$];
    logic [31:0] handed_out [$];
    int          err_count = 0;
    int          idle_pct  = IDLE_PCT;
    int          hold_req  = 0;
    int          hold_seen = 0;
    int          hold_left = 0;

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  cpu;
        logic [31:0] addr;
        logic        typed;
        out_word_t   want;
    } dir_row_t;

    // directed words, reset bounds 0x8000_0000 .. 0x8800_0000
    dir_row_t dir_rows [0:DIR_ROWS-1] = '{
        '{OP_ALLOC, 3'd0, 32'h0000_0000, 1'b1, '{ST_OOM,   32'h0,         3'd0, 1'b0}},
        '{OP_FREE,  3'd1, 32'h8000_0001, 1'b1, '{ST_BAD,   32'h0,         3'd0, 1'b0}},
        '{OP_FREE,  3'd1, 32'h7FFF_F000, 1'b1, '{ST_BAD,   32'h0,         3'd0, 1'b0}},
        '{OP_FREE,  3'd1, 32'h8800_0000, 1'b1, '{ST_BAD,   32'h0,         3'd0, 1'b0}},
        '{OP_FREE,  3'd1, 32'hFFFF_FFFF, 1'b1, '{ST_BAD,   32'h0,         3'd0, 1'b0}},
        '{OP_FREE,  3'd1, 32'h0000_0000, 1'b1, '{ST_BAD,   32'h0,         3'd0, 1'b0}},
        '{OP_FREE,  3'd3, 32'h8000_0000, 1'b1, '{ST_FREED, 32'h0,         3'd0, 1'b0}},
        '{OP_ALLOC, 3'd5, 32'hFFFF_FFFF, 1'b1, '{ST_ALLOC, 32'h8000_0000, 3'd3, 1'b1}},
        '{OP_FREE,  3'd7, 32'h87FF_F000, 1'b1, '{ST_FREED, 32'h0,         3'd0, 1'b0}},
        '{OP_ALLOC, 3'd7, 32'h0000_0000, 1'b1, '{ST_ALLOC, 32'h87FF_F000, 3'd7, 1'b0}},
        '{OP_ALLOC, 3'd6, 32'h0000_0000, 1'b1, '{ST_OOM,   32'h0,         3'd0, 1'b0}},
        '{OP_NONE,  3'd2, 32'hFFFF_FFFF, 1'b0, NO_FIX},
        '{OP_FREE,  3'd2, 32'h8000_1000, 1'b1, '{ST_FREED, 32'h0,         3'd0, 1'b0}},
        '{OP_FREE,  3'd2, 32'h8000_2000, 1'b1, '{ST_FREED, 32'h0,         3'd0, 1'b0}},
        '{OP_ALLOC, 3'd2, 32'h0000_0000, 1'b1, '{ST_ALLOC, 32'h8000_2000, 3'd2, 1'b0}},
        '{OP_FREE,  3'd4, 32'h8000_3000, 1'b0, NO_FIX},
        '{OP_ALLOC, 3'd0, 32'hFFFF_FFFF, 1'b0, NO_FIX},
        '{OP_FREE,  3'd2, 32'h8000_5000, 1'b0, NO_FIX},
        '{OP_FREE,  3'd2, 32'h8000_5000, 1'b0, NO_FIX},
        '{OP_ALLOC, 3'd2, 32'h0000_0000, 1'b0, NO_FIX},
        '{OP_ALLOC, 3'd2, 32'h0000_0000, 1'b0, NO_FIX},
        '{OP_INIT,  3'd1, 32'h0000_0000, 1'b1, '{ST_INIT,  32'h0,         3'd0, 1'b0}},
        '{OP_ALLOC, 3'd1, 32'h0000_0000, 1'b1, '{ST_ALLOC, 32'h87FF_F000, 3'd1, 1'b0}},
        '{OP_ALLOC, 3'd6, 32'h0000_0000, 1'b0, NO_FIX},
        '{OP_ALLOC, 3'd4, 32'h0000_0000, 1'b0, NO_FIX}
    };

    per_cpu_page_free_list #(
        .NUM_CPUS   (NCPU),
        .NUM_PAGES  (NPG),
        .PAGE_SHIFT (PSH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // first whole page at or above mem_start
    function automatic logic [63:0] base_page();
        return ({32'd0, cur_start} + PG_BYTES - 64'd1) >> PSH;
    endfunction

    // address of a slot inside the window of NPG pages from the base page
    function automatic logic [31:0] slot_addr(logic [15:0] slot);
        logic [63:0] b;
        logic [63:0] off;
        b   = base_page();
        off = ({48'd0, slot} + 64'(NPG) - (b % 64'(NPG))) % 64'(NPG);
        return 32'((b + off) << PSH);
    endfunction

    function automatic void push_slot(int c, logic [63:0] page);
        logic [15:0] s;
        s = 16'(page % 64'(NPG));
        link_ram[s]  = head_used[c] ? {1'b1, head_page[c]} : 17'd0;
        head_page[c] = s;
        head_used[c] = 1'b1;
    endfunction

    function automatic logic [15:0] pop_slot(int c);
        logic [15:0] s;
        logic [16:0] lk;
        s  = head_page[c] % 16'(NPG);
        lk = link_ram[s];
        head_used[c] = lk[16];
        head_page[c] = lk[15:0];
        return s;
    endfunction

    // number of pages an init pushes under the current bounds
    function automatic int init_len();
        logic [63:0] p;
        int          n;
        p = base_page() << PSH;
        n = 0;
        while (n < NPG && p + PG_BYTES <= {32'd0, cur_stop})
        begin
            p += PG_BYTES;
            n++;
        end
        return n;
    endfunction

    // advance the allocator by one word, tell whether it answers
    function automatic bit apply_word(input in_word_t w, output out_word_t r);
        int          c;
        int          from;
        int          n;
        logic [63:0] p;
        c = int'(w.cpu_id) % NCPU;
        r = '0;
        case (w.opcode)
            OP_ALLOC:
            begin
                from = -1;
                if (head_used[c])
                    from = c;
                else
                    for (int i = NCPU - 1; i >= 0; i--)
                        if (head_used[i])
                            from = i;
                if (from < 0)
                    r.status = ST_OOM;
                else
                begin
                    r.status      = ST_ALLOC;
                    r.result_addr = slot_addr(pop_slot(from));
                    r.source_cpu  = 3'(from);
                    r.stolen      = (from != c);
                end
                return 1'b1;
            end
            OP_FREE:
            begin
                if (w.page_addr[PSH-1:0] != '0 || w.page_addr < cur_start
                    || w.page_addr >= cur_stop)
                    r.status = ST_BAD;
                else
                begin
                    push_slot(c, {32'd0, w.page_addr} >> PSH);
                    r.status = ST_FREED;
                end
                return 1'b1;
            end
            OP_INIT:
            begin
                n = init_len();
                p = base_page() << PSH;
                for (int k = 0; k < n; k++)
                begin
                    push_slot(c, p >> PSH);
                    p += PG_BYTES;
                end
                r.status = ST_INIT;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // free address: mostly pages handed out before or pages in the window
    function automatic logic [31:0] pick_free_addr();
        logic [63:0] b;
        logic [63:0] span;
        logic [31:0] a;
        int          sel;
        int          k;
        b    = base_page();
        span = 0;
        if ({32'd0, cur_stop} > (b << PSH))
            span = ({32'd0, cur_stop} - (b << PSH)) >> PSH;
        sel = $urandom_range(0, 99);
        if (sel < 45 && handed_out.size() != 0)
        begin
            k = $urandom_range(0, handed_out.size() - 1);
            a = handed_out[k];
            handed_out.delete(k);
            return a;
        end
        a = $urandom;
        if (span != 0)
            a = 32'((b + 64'($urandom_range(0, 32'(span - 1)))) << PSH);
        if (sel >= 70)
        begin
            case (sel % 4)
                0: a = $urandom;
                1: a[PSH-1:0] = PSH'($urandom_range(1, (1 << PSH) - 1));
                2: a = cur_stop;
                default: a = {cur_start[31:PSH], {PSH{1'b0}}};
            endcase
        end
        return a;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        if (err_count <= 40)
            $display("mismatch at %0t ns: %s got %h want %h", $time, what, got, want);
    endtask

    // present one word, wait for it to be taken, then predict its result
    task automatic send_word(input in_word_t w, input bit fixed, input out_word_t fixed_word);
        out_word_t r;
        bit        has_r;
        if ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < 50);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        has_r = apply_word(w, r);
        if (has_r)
        begin
            if (fixed)
                r = fixed_word;
            expected_words.push_back(r);
            if (r.status == ST_ALLOC)
                handed_out.push_back(r.result_addr);
        end
    endtask

    // stop sending and let every outstanding word come back
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_MEM_START)
            cur_start = val;
        else
            cur_stop = val;
    endtask

    task automatic set_window(input logic [31:0] lo, input logic [31:0] hi);
        if ($urandom_range(0, 1))
        begin
            write_reg(REG_MEM_START, lo);
            write_reg(REG_MEM_STOP, hi);
        end
        else
        begin
            write_reg(REG_MEM_STOP, hi);
            write_reg(REG_MEM_START, lo);
        end
        cfg_valid <= 1'b0;
    endtask

    // result side: random stalls plus an occasional long hold
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
        end
        out_stall <= (hold_left > 1) || (hold_seen != hold_req)
                     || ($urandom_range(0, 99) < idle_pct);
    end

    // compare each result word with the oldest prediction
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
                report_mismatch("word with none expected", {29'd0, out_word.status}, 32'd0);
            else
            begin
                want = expected_words.pop_front();
                if (out_word.status != want.status)
                    report_mismatch("status", {29'd0, out_word.status}, {29'd0, want.status});
                if (out_word.result_addr != want.result_addr)
                    report_mismatch("result_addr", out_word.result_addr, want.result_addr);
                if (out_word.source_cpu != want.source_cpu)
                    report_mismatch("source_cpu", {29'd0, out_word.source_cpu},
                                    {29'd0, want.source_cpu});
                if (out_word.stolen != want.stolen)
                    report_mismatch("stolen", {31'd0, out_word.stolen}, {31'd0, want.stolen});
            end
        end
    end

    // stimulus
    initial
    begin
        in_word_t    w;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [63:0] top;
        int          sent;
        int          phase;
        int          sel;
        bit          small_win;
        sent  = 0;
        phase = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (dir_rows[i])
        begin
            w.opcode    = dir_rows[i].op;
            w.cpu_id    = dir_rows[i].cpu;
            w.page_addr = dir_rows[i].addr;
            send_word(w, dir_rows[i].typed, dir_rows[i].want);
        end
        drain();

        // random phases, one memory window each
        while (sent < RAND_ITEMS)
        begin
            case (phase)
                0:
                begin
                    lo = 32'h0000_0000;
                    hi = 32'hFFFF_FFFF;
                end
                1:
                begin
                    lo = 32'hFFFF_FFFF;
                    hi = 32'h0000_0000;
                end
                2:
                begin
                    lo = 32'hFFFF_F001;
                    hi = 32'hFFFF_FFFF;
                end
                CALM_PHASE:
                begin
                    lo = 32'hFFFF_0000;
                    hi = 32'hFFFF_FFFF;
                end
                HOLD_PHASE:
                begin
                    lo = MEM_START_INIT;
                    hi = MEM_START_INIT + 32'h0002_0000;
                end
                default:
                begin
                    lo = $urandom;
                    if ($urandom_range(0, 1))
                        lo[PSH-1:0] = '0;
                    if ($urandom_range(0, 9) == 0)
                        hi = lo - 32'($urandom_range(0, 8192));
                    else
                    begin
                        top = {32'd0, lo} + 64'($urandom_range(1, 48)) * PG_BYTES
                              + 64'($urandom_range(0, 4095));
                        hi = (top > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : top[31:0];
                    end
                end
            endcase
            idle_pct <= (phase == CALM_PHASE) ? 0 : IDLE_PCT;
            set_window(lo, hi);
            small_win = (init_len() <= SMALL_INIT);
            handed_out.delete();

            // fill one list first so allocs and steals have pages to take
            w.opcode    = OP_INIT;
            w.cpu_id    = 3'($urandom);
            w.page_addr = $urandom;
            send_word(w, 1'b0, NO_FIX);
            sent++;

            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                w.cpu_id    = 3'($urandom);
                w.page_addr = $urandom;
                sel = $urandom_range(0, 99);
                if (sel < 42)
                    w.opcode = OP_ALLOC;
                else if (sel < 88)
                begin
                    w.opcode    = OP_FREE;
                    w.page_addr = pick_free_addr();
                end
                else if (sel < 94)
                    w.opcode = small_win ? OP_INIT : OP_ALLOC;
                else
                    w.opcode = OP_NONE;
                send_word(w, 1'b0, NO_FIX);
                if (w.opcode != OP_NONE)
                    sent++;
                if (phase == HOLD_PHASE && k == 20)
                    hold_req <= hold_req + 1;
                if (phase == PAUSE_PHASE && k == 60)
                    drain();
            end
            drain();
            phase++;
        end

        drain();
        repeat (2 * SETTLE) @(posedge clk);
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #16_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
